// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rstn, a, c)
`define ASSERT_NEXT(label, clk, rstn, a, c)
`endif
`endif

// ===== sv/mgrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mgrc_pkg
// shared types and codes for the motor goal ramp controller
// ----------------------------------------------------------------------------
package mgrc_pkg;
    localparam logic [1:0] FUNC_UPDATE = 2'd0;
    localparam logic [1:0] FUNC_GOAL   = 2'd1;
    localparam logic [1:0] FUNC_STOP   = 2'd2;
    localparam logic [1:0] FUNC_BRAKE  = 2'd3;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_OVERRUN = 2'd1;
    localparam logic [1:0] CAUSE_STALL   = 2'd2;

    localparam logic [2:0] REG_ACCEL  = 3'd0;
    localparam logic [2:0] REG_SLOW   = 3'd1;
    localparam logic [2:0] REG_ARRIVE = 3'd2;
    localparam logic [2:0] REG_BRAKE  = 3'd3;
    localparam logic [2:0] REG_MINPWM = 3'd4;
    localparam logic [2:0] REG_CUTOFF = 3'd5;
    localparam logic [2:0] REG_STALL  = 3'd6;

    localparam int CFG_W = 20;

    // quotient bits produced by the restoring divider
    localparam int DIV_STEPS = 28;

    // datapath micro-operations issued by the controller
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1; // latch request, compute distances
    localparam logic [2:0] OP_DIVSET = 3'd2; // load divider with numerator
    localparam logic [2:0] OP_DIVSTP = 3'd3; // one divider step
    localparam logic [2:0] OP_APPLY  = 3'd4; // commit the command

    typedef struct packed {
        logic [2:0] op;
        logic       sel_slow; // divide by slow zone instead of accel time
    } mgrc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic use_slow;
        logic [1:0] func;
    } mgrc_stat_t;
endpackage

// ===== sv/mgrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mgrc_ctrl
// sequencer: accepts a request, runs the divider, commits, presents result
// ----------------------------------------------------------------------------
module mgrc_ctrl import mgrc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  mgrc_stat_t stat,
    output mgrc_cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_APP  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam int CW = $clog2(DIV_STEPS + 1);

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sel_reg, sel_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd.op       = OP_NONE;
        cmd.sel_slow = sel_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (stat.need_div) begin
                    cmd.op       = OP_DIVSET;
                    cmd.sel_slow = stat.use_slow;
                    sel_next     = stat.use_slow;
                    cnt_next     = CW'(DIV_STEPS);
                    state_next   = ST_DIV;
                end else begin
                    state_next = ST_APP;
                end
            end
            ST_DIV: begin
                cmd.op   = OP_DIVSTP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) state_next = ST_APP;
            end
            ST_APP: begin
                cmd.op     = OP_APPLY;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end
endmodule

// ===== sv/mgrc_dp.sv =====
// ----------------------------------------------------------------------------
// mgrc_dp
// datapath: state registers, distance logic, restoring divider, result
// ----------------------------------------------------------------------------
module mgrc_dp import mgrc_pkg::*; #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [1:0]        s_func,
    input  logic signed [31:0] s_position,
    input  logic signed [31:0] s_goal,
    input  logic [31:0]       s_now_ms,
    input  mgrc_cmd_t         cmd,
    output mgrc_stat_t        stat,
    output logic [7:0]        m_pwm,
    output logic              m_reverse,
    output logic              m_arrived,
    output logic              m_braking,
    output logic [1:0]        m_stop_cause
);
    localparam logic [33:0] TWO_FRAC = 34'd2 << POS_FRAC_BITS;
    localparam logic [32:0] ONE_FRAC = 33'd1 << POS_FRAC_BITS;

    logic [15:0] accel_reg, arrive_reg, bdist_reg, stall_reg;
    logic [19:0] slow_reg;
    logic [7:0]  minpwm_reg, cutoff_reg;

    logic signed [31:0] target_reg, lastpos_reg, pos_reg, goal_reg;
    logic [31:0] now_reg, mstart_reg, still_reg;
    logic [7:0]  duty_reg;
    logic        brake_reg, dir_reg;
    logic [1:0]  func_reg;
    logic [32:0] d_reg;       // |pos - target|
    logic [31:0] elapsed_reg;
    logic [1:0]  cause_reg;

    // restoring divider, quotient saturation handled after
    logic [40:0] rem_reg;
    logic [27:0] quo_reg;
    logic [19:0] den_reg;

    logic [32:0] dd;
    logic signed [32:0] diff;
    logic [32:0] dtl;
    logic signed [32:0] dtl_s;

    always_comb begin
        diff  = 33'(s_position) - 33'(target_reg);
        dd    = diff[32] ? 33'(-diff) : diff;
        dtl_s = 33'(target_reg) - 33'(lastpos_reg);
        dtl   = dtl_s[32] ? 33'(-dtl_s) : dtl_s;
    end

    logic acc_ramp;
    always_comb begin
        acc_ramp = (elapsed_reg < 32'(accel_reg)) && (accel_reg != 16'd0);
        stat.func     = func_reg;
        stat.use_slow = (d_reg <= 33'(slow_reg));
        stat.need_div = (func_reg == FUNC_UPDATE) &&
            ((d_reg > 33'(slow_reg)) ? acc_ramp :
             (d_reg > 33'(arrive_reg)));
    end

    logic [40:0] rem_sh;
    logic [40:0] rem_sub;
    always_comb begin
        rem_sh  = {rem_reg[39:0], quo_reg[27]};
        rem_sub = rem_sh - 41'(den_reg);
    end

    // duty selection
    logic [7:0] p;
    logic       idle_upd;
    logic       give_up;
    always_comb begin
        idle_upd = (dtl < 33'(arrive_reg)) && (duty_reg == 8'd0);
        if (d_reg > 33'(slow_reg)) begin
            p = acc_ramp ? ((quo_reg > 28'd255) ? 8'd255 : quo_reg[7:0]) : 8'd255;
        end else if (d_reg > 33'(arrive_reg)) begin
            p = (quo_reg > 28'd255) ? 8'd255 : quo_reg[7:0];
            if (p < minpwm_reg) p = minpwm_reg;
        end else begin
            p = 8'd0;
        end
        if (p < cutoff_reg) p = 8'd0;
        give_up = (p == 8'd0) &&
            (((35'(d_reg) * 35'd5 < 35'(TWO_FRAC)) && (elapsed_reg > 32'd1000)) ||
             ((d_reg < ONE_FRAC) && (elapsed_reg > 32'd5000)));
    end

    // three times the distance needs two bits above the 33-bit distance
    logic [34:0] fwd_s;
    logic signed [33:0] bp, bm;
    logic signed [31:0] bt;
    always_comb begin
        bp = 34'(lastpos_reg) + 34'(bdist_reg);
        bm = 34'(lastpos_reg) - 34'(bdist_reg);
        if (target_reg > lastpos_reg)
            bt = (bp > 34'sh07fffffff) ? 32'sh7fffffff : bp[31:0];
        else
            bt = (bm < -34'sh080000000) ? 32'sh80000000 : bm[31:0];
        fwd_s = 35'(dtl) * 35'd3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg  <= 16'd2000;
            slow_reg   <= 20'd1280;
            arrive_reg <= 16'd26;
            bdist_reg  <= 16'd128;
            minpwm_reg <= 8'd12;
            cutoff_reg <= 8'd10;
            stall_reg  <= 16'd3000;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ACCEL:  accel_reg  <= cfg_data[15:0];
                REG_SLOW:   slow_reg   <= cfg_data;
                REG_ARRIVE: arrive_reg <= cfg_data[15:0];
                REG_BRAKE:  bdist_reg  <= cfg_data[15:0];
                REG_MINPWM: minpwm_reg <= cfg_data[7:0];
                REG_CUTOFF: cutoff_reg <= cfg_data[7:0];
                REG_STALL:  stall_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD) begin
            func_reg    <= s_func;
            pos_reg     <= s_position;
            goal_reg    <= s_goal;
            now_reg     <= s_now_ms;
            d_reg       <= dd;
            elapsed_reg <= s_now_ms - mstart_reg;
        end
        if (cmd.op == OP_DIVSET) begin
            rem_reg <= '0;
            // numerator loaded into the quotient register as is, msb shifted out first
            quo_reg <= cmd.sel_slow ? 28'(d_reg[19:0] * 28'd255)
                                    : 28'(elapsed_reg[15:0] * 28'd255);
            den_reg <= cmd.sel_slow ? slow_reg : 20'(accel_reg);
        end else if (cmd.op == OP_DIVSTP) begin
            if (!rem_sub[40]) begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[26:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[26:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            lastpos_reg <= '0;
            duty_reg    <= '0;
            mstart_reg  <= '0;
            still_reg   <= '0;
            brake_reg   <= 1'b0;
            dir_reg     <= 1'b0;
            cause_reg   <= CAUSE_NONE;
        end else if (cmd.op == OP_APPLY) begin
            cause_reg <= CAUSE_NONE;
            case (func_reg)
                FUNC_UPDATE: begin
                    if (!idle_upd) begin
                        if ((duty_reg != p) && brake_reg && (p > duty_reg)) begin
                            target_reg <= lastpos_reg;
                            duty_reg   <= 8'd0;
                            brake_reg  <= 1'b0;
                            cause_reg  <= CAUSE_OVERRUN;
                        end else if (lastpos_reg != pos_reg) begin
                            duty_reg    <= p;
                            lastpos_reg <= pos_reg;
                            still_reg   <= now_reg;
                            target_reg  <= give_up ? pos_reg : target_reg;
                        end else if ((p != 8'd0) &&
                                     ((now_reg - still_reg) > 32'(stall_reg))) begin
                            target_reg <= lastpos_reg;
                            duty_reg   <= 8'd0;
                            brake_reg  <= 1'b0;
                            cause_reg  <= CAUSE_STALL;
                        end else begin
                            duty_reg   <= p;
                            target_reg <= give_up ? lastpos_reg : target_reg;
                        end
                    end
                end
                FUNC_GOAL: begin
                    target_reg <= goal_reg;
                    mstart_reg <= now_reg;
                    still_reg  <= now_reg;
                    brake_reg  <= 1'b0;
                    dir_reg    <= goal_reg < lastpos_reg;
                end
                FUNC_STOP: begin
                    target_reg <= lastpos_reg;
                    duty_reg   <= 8'd0;
                    brake_reg  <= 1'b0;
                end
                default: begin
                    if (!brake_reg) begin
                        if ((duty_reg == 8'd0) || (fwd_s < 35'(bdist_reg))) begin
                            target_reg <= lastpos_reg;
                            duty_reg   <= 8'd0;
                        end else begin
                            brake_reg <= 1'b1;
                            if (dtl >= 33'(bdist_reg)) target_reg <= bt;
                        end
                    end
                end
            endcase
        end
    end

    logic signed [32:0] od_s;
    always_comb begin
        od_s = 33'(target_reg) - 33'(lastpos_reg);
        m_arrived = ((od_s[32] ? 33'(-od_s) : od_s) < 33'(arrive_reg));
    end
    assign m_pwm        = duty_reg;
    assign m_reverse    = dir_reg;
    assign m_braking    = brake_reg;
    assign m_stop_cause = cause_reg;
endmodule

// ===== sv/motor_goal_ramp_controller_top.sv =====
// ----------------------------------------------------------------------------
// motor_goal_ramp_controller_top
// position goal controller with pwm ramp, slow zone, brake and stall stop
// ----------------------------------------------------------------------------
// One request at a time: when no division is needed the result is presented
// after the decode and apply states; when the duty comes from the ramp or
// slow-zone ratio, set by the 28-step restoring divider, the divider runs between decode and apply; the next
// request is taken in the cycle after the result is accepted.
`include "assert_macros.svh"
module motor_goal_ramp_controller_top import mgrc_pkg::*; #(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_position,
    input  logic signed [31:0] s_goal,
    input  logic [31:0]        s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pwm,
    output logic               m_reverse,
    output logic               m_arrived,
    output logic               m_braking,
    output logic [1:0]         m_stop_cause
);
    mgrc_cmd_t  cmd;
    mgrc_stat_t stat;

    mgrc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    mgrc_dp #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_func(s_func), .s_position(s_position),
        .s_goal(s_goal), .s_now_ms(s_now_ms), .cmd(cmd), .stat(stat),
        .m_pwm(m_pwm), .m_reverse(m_reverse), .m_arrived(m_arrived),
        .m_braking(m_braking), .m_stop_cause(m_stop_cause)
    );

    `ASSERT_IMPLY(a_no_overlap, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `ASSERT_NEXT(a_take_then_busy, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPLY(a_cause_code, aclk, aresetn, m_valid, m_stop_cause <= CAUSE_STALL)
    `ASSERT_IMPLY(a_cause_zero_duty, aclk, aresetn, m_stop_cause != CAUSE_NONE, m_pwm == 8'd0)
endmodule
